### hw/rtl/frequency_ordered_list_assert.svh
// Assertion macros for the frequency-ordered list.
// Used by fol_ctrl; expects signals clk and arst_n in scope.
`ifndef FREQUENCY_ORDERED_LIST_ASSERT_SVH
`define FREQUENCY_ORDERED_LIST_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FOL_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("fol assertion failed");
`define FOL_ASSERT_RST(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("fol assertion failed");
`else
`define FOL_ASSERT(lbl, prop)
`define FOL_ASSERT_RST(lbl, prop)
`endif
`endif

### hw/rtl/fol_pkg.sv
// Package for the frequency-ordered list: sizes, codes and word types.
// No dependencies; used by fol_mem, fol_ctrl and frequency_ordered_list.
package fol_pkg;
	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic [1:0] FN_APPEND = 2'd0;
	localparam logic [1:0] FN_ACCESS = 2'd1;
	localparam logic [1:0] FN_READ   = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_MISSING = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_RANGE   = 2'd3;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] key;
		logic [3:0] position;
	} fol_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  key_out;
		logic [15:0] count_out;
		logic [3:0]  position_out;
		logic [4:0]  length_out;
	} fol_out_t;

	typedef struct packed {
		logic [7:0]  key;
		logic [15:0] cnt;
	} fol_ent_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		fol_ent_t         wdata;
		logic [IDX_W-1:0] raddr;
	} fol_memctl_t;
endpackage

### hw/rtl/fol_mem.sv
// Entry table storage: key and count per position, one write and one read port.
// Depends on fol_pkg. Read data is registered.
module fol_mem (
	input  logic                clk,
	input  fol_pkg::fol_memctl_t ctl,
	output fol_pkg::fol_ent_t   rdata
);
	fol_pkg::fol_ent_t mem_q [fol_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem_q[ctl.waddr] <= ctl.wdata;
		end
		rdata <= mem_q[ctl.raddr];
	end
endmodule

### hw/rtl/fol_ctrl.sv
// Sequencer for the frequency-ordered list: search, count update, move toward head.
// Depends on fol_pkg and frequency_ordered_list_assert.svh; drives fol_mem.
`include "frequency_ordered_list_assert.svh"
module fol_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  fol_pkg::fol_in_t     cmd,
	output logic                 busy,
	output logic                 done,
	output fol_pkg::fol_out_t    rsp,
	output fol_pkg::fol_memctl_t mctl,
	input  fol_pkg::fol_ent_t    rdata
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SRD  = 3'd1;
	localparam logic [2:0] S_SCMP = 3'd2;
	localparam logic [2:0] S_MRD  = 3'd3;
	localparam logic [2:0] S_MCMP = 3'd4;
	localparam logic [2:0] S_MWR  = 3'd5;
	localparam logic [2:0] S_RD   = 3'd6;

	logic [2:0]               state_q;
	logic [fol_pkg::IDX_W-1:0] idx_q;
	logic [fol_pkg::CNT_W-1:0] total_q;
	logic [7:0]               key_q;
	logic [15:0]              cnt_q;
	logic                     done_q;
	fol_pkg::fol_out_t        rsp_q;
	fol_pkg::fol_out_t        rsp_idle;
	logic [fol_pkg::IDX_W-1:0] idx_dec;
	logic [15:0]              cnt_inc;
	logic                     accept;
	logic                     full;
	logic                     last;
	logic                     in_range;

	assign accept   = start && (state_q == S_IDLE);
	assign idx_dec  = idx_q - fol_pkg::IDX_W'(1);
	assign cnt_inc  = (rdata.cnt == 16'hFFFF) ? rdata.cnt : rdata.cnt + 16'd1;
	assign full     = (32'(total_q) >= fol_pkg::DEPTH);
	assign last     = ((32'(idx_q) + 32'd1) == 32'(total_q));
	assign in_range = (32'(cmd.position) < 32'(total_q));

	// memory port control
	always_comb begin
		mctl = '0;
		unique case (state_q) inside
			S_IDLE: begin
				mctl.raddr = fol_pkg::IDX_W'(cmd.position);
				mctl.waddr = fol_pkg::IDX_W'(total_q);
				mctl.wdata = '{key: cmd.key, cnt: 16'd0};
				mctl.we    = accept && (cmd.func == fol_pkg::FN_APPEND) && !full;
			end
			S_SRD, S_SCMP: begin
				mctl.raddr = idx_q;
			end
			S_MRD: begin
				mctl.raddr = idx_dec;
			end
			S_MCMP: begin
				mctl.waddr = idx_q;
				mctl.wdata = rdata;
				mctl.we    = (rdata.cnt < cnt_q);
			end
			S_MWR: begin
				mctl.waddr = idx_q;
				mctl.wdata = '{key: key_q, cnt: cnt_q};
				mctl.we    = 1'b1;
			end
			S_RD: begin
				mctl.raddr = idx_q;
			end
			default: begin
				mctl = '0;
			end
		endcase
	end

	// result word registered at acceptance; final for all but access hits and in-range reads
	always_comb begin
		rsp_idle            = '0;
		rsp_idle.key_out    = cmd.key;
		rsp_idle.length_out = 5'(total_q);
		unique case (cmd.func)
			fol_pkg::FN_APPEND: begin
				if (full) begin
					rsp_idle.status = fol_pkg::ST_FULL;
				end else begin
					rsp_idle.status       = fol_pkg::ST_OK;
					rsp_idle.position_out = 4'(total_q);
					rsp_idle.length_out   = 5'(total_q + fol_pkg::CNT_W'(1));
				end
			end
			fol_pkg::FN_ACCESS: rsp_idle.status = fol_pkg::ST_MISSING;
			fol_pkg::FN_READ: begin
				rsp_idle.status       = fol_pkg::ST_RANGE;
				rsp_idle.key_out      = 8'd0;
				rsp_idle.position_out = cmd.position;
			end
			default: begin
				rsp_idle.status  = fol_pkg::ST_OK;
				rsp_idle.key_out = 8'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			total_q <= '0;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (cmd.func)
							fol_pkg::FN_APPEND: begin
								done_q <= 1'b1;
								if (!full) begin
									total_q <= total_q + fol_pkg::CNT_W'(1);
								end
							end
							fol_pkg::FN_ACCESS: begin
								done_q <= (total_q == '0);
								if (total_q != '0) begin
									state_q <= S_SRD;
								end
							end
							fol_pkg::FN_READ: begin
								done_q <= !in_range;
								if (in_range) begin
									state_q <= S_RD;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end else begin
						done_q <= 1'b0;
					end
				end
				S_SRD: begin
					state_q <= S_SCMP;
					done_q  <= 1'b0;
				end
				S_SCMP: begin
					done_q <= (rdata.key != key_q) && last;
					if (rdata.key == key_q) begin
						state_q <= (idx_q == '0) ? S_MWR : S_MRD;
					end else if (last) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_SRD;
					end
				end
				S_MRD: begin
					state_q <= S_MCMP;
					done_q  <= 1'b0;
				end
				S_MCMP: begin
					done_q <= 1'b0;
					if ((rdata.cnt < cnt_q) && (idx_dec != '0)) begin
						state_q <= S_MRD;
					end else begin
						state_q <= S_MWR;
					end
				end
				S_MWR: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				S_RD: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	// datapath and result word
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				key_q <= cmd.key;
				idx_q <= (cmd.func == fol_pkg::FN_READ) ? fol_pkg::IDX_W'(cmd.position) : '0;
				rsp_q <= rsp_idle;
			end
			S_SCMP: begin
				cnt_q <= cnt_inc;
				if (rdata.key != key_q) begin
					idx_q <= idx_q + fol_pkg::IDX_W'(1);
				end
			end
			S_MCMP: begin
				if (rdata.cnt < cnt_q) begin
					idx_q <= idx_dec;
				end
			end
			S_MWR: begin
				rsp_q.status       <= fol_pkg::ST_OK;
				rsp_q.key_out      <= key_q;
				rsp_q.count_out    <= cnt_q;
				rsp_q.position_out <= 4'(idx_q);
			end
			S_RD: begin
				rsp_q.status       <= fol_pkg::ST_OK;
				rsp_q.key_out      <= rdata.key;
				rsp_q.count_out    <= rdata.cnt;
				rsp_q.position_out <= 4'(idx_q);
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	`FOL_ASSERT(a_total_bound, 32'(total_q) <= fol_pkg::DEPTH)
	`FOL_ASSERT(a_done_idle, done_q |-> (state_q == S_IDLE))
	`FOL_ASSERT(a_append_one, (accept && cmd.func == fol_pkg::FN_APPEND) |=> done_q)
	`FOL_ASSERT(a_total_src, (total_q != $past(total_q)) |-> $past(accept && cmd.func == fol_pkg::FN_APPEND))
	`FOL_ASSERT(a_move_idx, (state_q == S_MRD) |-> (idx_q != '0))
	`FOL_ASSERT_RST(a_rst_idle, !arst_n |=> (state_q == S_IDLE || arst_n))
endmodule

### hw/rtl/frequency_ordered_list.sv
// Top level of the frequency-ordered list (self-organizing, frequency-count rule).
// Depends on fol_pkg, fol_ctrl and fol_mem.
//
// Usage:
//   A command word (cmd: func, key, position) is taken at a rising edge where
//   start is high and busy is low. Exactly one result word appears on rsp for
//   one cycle with done high; the receiver cannot stall and must take it.
// Sequence, from the accepting edge to the done cycle:
//   append, access on an empty table, out-of-range read, unused code: no table walk.
//   read in range: one table read (S_RD).
//   access hit: a read and compare per entry searched up to the hit (S_SRD,
//   S_SCMP), a read and compare per earlier entry compared on the way to the
//   head (S_MRD, S_MCMP), then the final write (S_MWR); a miss searches every held entry.
//   The single table port and its registered read set this sequence.
// busy is high while a command that reads the table runs and falls as done rises; the
// next command may be taken in the done cycle. One command at a time.
// Reset clears the entry count and the sequencer; entry storage is not cleared
// and only data read from positions below the count is ever used.
module frequency_ordered_list (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  fol_pkg::fol_in_t  cmd,
	output logic              busy,
	output logic              done,
	output fol_pkg::fol_out_t rsp
);
	fol_pkg::fol_memctl_t mctl;
	fol_pkg::fol_ent_t    rdata;

	fol_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp),
		.mctl   (mctl),
		.rdata  (rdata)
	);

	fol_mem u_mem (
		.clk   (clk),
		.ctl   (mctl),
		.rdata (rdata)
	);
endmodule
